// ----- rtl/stt_pkg.sv -----
// Package for the session timer table: operation codes, status codes, widths
// and the command record passed from front end to back end. No dependencies.
package stt_pkg;

    localparam int MaxTimers = 32;
    localparam int IdxW      = $clog2(MaxTimers);
    localparam int TickW     = 48;
    localparam int TpsW      = 10;
    localparam int TmoW      = 24;
    localparam int SesW      = 32;
    localparam int TypW      = 8;
    localparam int CntW      = 6;
    localparam int EntW      = SesW + TypW + TickW;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_CALL   = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCAN,
        BK_CHECK,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        op_t             op;
        logic [SesW-1:0] session;
        logic [TypW-1:0] ttype;
        logic [TmoW-1:0] tmo;
    } cmd_t;

endpackage

// ----- rtl/stt_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module stt_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/stt_front.sv -----
// Front end: takes commands, holds them in a two-entry queue for the back end.
// Depends on stt_pkg.
module stt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  stt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output stt_pkg::cmd_t head
);

    stt_pkg::cmd_t q_reg [2];
    logic          rd_reg, rd_next;
    logic          wr_reg, wr_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = q_reg[rd_reg];

    always_comb
    begin
        rd_next  = pop ? ~rd_reg : rd_reg;
        wr_next  = push ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/stt_back.sv -----
// Back end: scans the table one entry a cycle for cancel, cancel-all and tick.
// Depends on stt_pkg and stt_ram.
module stt_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  stt_pkg::cmd_t            cmd,
    output logic                     cmd_pop,
    input  logic [stt_pkg::TpsW-1:0] tps,
    output logic                     active,
    output logic                     strobe,
    output logic                     result_kind,
    output logic [1:0]               status,
    output logic [31:0]              expired_session,
    output logic [7:0]               expired_kind,
    output logic [5:0]               removed_count,
    output logic                     last
);

    localparam int N  = stt_pkg::MaxTimers;
    localparam int IW = stt_pkg::IdxW;
    localparam int TW = stt_pkg::TickW;
    localparam int TpsW_l = stt_pkg::TpsW;

    stt_pkg::bk_state_t state_reg, state_next;
    stt_pkg::cmd_t      cur_reg;
    logic [N-1:0]       valid_reg, valid_next;
    logic [TW-1:0]      now_reg, now_next;
    logic [TW-1:0]      prod_reg;
    logic [IW:0]        idx_reg, idx_next;
    logic [IW:0]        cnt_reg, cnt_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic               pend_reg, pend_next;
    logic [stt_pkg::SesW-1:0] pses_reg;
    logic [stt_pkg::TypW-1:0] ptyp_reg;
    logic               load;

    logic                     we;
    logic [IW-1:0]            raddr;
    logic [stt_pkg::EntW-1:0] wdata, rdata;
    logic [stt_pkg::SesW-1:0] r_ses;
    logic [stt_pkg::TypW-1:0] r_typ;
    logic [TW-1:0]            r_exp, diff;
    logic                     hit, due;
    logic [TpsW_l-1:0]        tps_eff;
    logic [stt_pkg::TmoW+TpsW_l-1:0] prod_w;
    logic [IW-1:0]            prev_idx;

    stt_ram #(.Width(stt_pkg::EntW), .Depth(N)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (slot_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign {r_ses, r_typ, r_exp} = rdata;
    assign tps_eff = (tps == '0) ? TpsW_l'(1) : tps;
    assign prod_w  = cur_reg.tmo * tps_eff;
    assign wdata   = {cur_reg.session, cur_reg.ttype, now_reg + prod_reg};
    assign raddr   = idx_reg[IW-1:0];
    assign diff    = now_reg - r_exp;
    assign due     = (diff[TW-1] == 1'b0);
    assign active  = (state_reg != stt_pkg::BK_IDLE);

    // entry examined this cycle is the one addressed last cycle
    assign prev_idx = IW'(idx_reg - 1'b1);

    always_comb
    begin
        unique case (cur_reg.op)
            stt_pkg::OP_CANCEL: hit = valid_reg[prev_idx] && r_ses == cur_reg.session
                                      && r_typ == cur_reg.ttype;
            stt_pkg::OP_CALL:   hit = valid_reg[prev_idx] && r_ses == cur_reg.session;
            stt_pkg::OP_TICK:   hit = valid_reg[prev_idx] && due;
            default:            hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        unique case (state_reg)
            stt_pkg::BK_IDLE:
                if (cmd_valid)
                begin
                    load       = 1'b1;
                    state_next = (cmd.op == stt_pkg::OP_ADD) ? stt_pkg::BK_MUL
                                                             : stt_pkg::BK_SCAN;
                end
            stt_pkg::BK_MUL:   state_next = stt_pkg::BK_DONE;
            stt_pkg::BK_SCAN:  state_next = stt_pkg::BK_CHECK;
            stt_pkg::BK_CHECK:
                if (idx_reg == (IW+1)'(N) || (cur_reg.op == stt_pkg::OP_CANCEL && hit))
                    state_next = stt_pkg::BK_DONE;
            stt_pkg::BK_DONE:  state_next = stt_pkg::BK_IDLE;
            default:           state_next = stt_pkg::BK_IDLE;
        endcase
    end

    assign cmd_pop = load;

    always_comb
    begin
        valid_next = valid_reg;
        now_next   = now_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        pend_next  = pend_reg;
        we         = 1'b0;
        unique case (state_reg)
            stt_pkg::BK_IDLE:
            begin
                idx_next   = '0;
                cnt_next   = '0;
                slot_next  = '0;
                for (int i = N - 1; i >= 0; i--)
                    if (!valid_reg[i]) slot_next = IW'(i);
                found_next = (cmd.op == stt_pkg::OP_ADD) && !(&valid_reg);
                if (load && cmd.op == stt_pkg::OP_TICK)
                    now_next = now_reg + 1'b1;
            end
            stt_pkg::BK_SCAN:  idx_next = idx_reg + 1'b1;
            stt_pkg::BK_CHECK:
            begin
                idx_next = idx_reg + 1'b1;
                if (hit)
                begin
                    valid_next[prev_idx] = 1'b0;
                    cnt_next             = cnt_reg + 1'b1;
                    found_next           = 1'b1;
                    if (cur_reg.op == stt_pkg::OP_TICK)
                        pend_next = 1'b1;
                end
            end
            stt_pkg::BK_DONE:
            begin
                pend_next = 1'b0;
                if (cur_reg.op == stt_pkg::OP_ADD && cur_reg.tmo != '0 && found_reg)
                begin
                    we                   = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // hold one expiry notice until the next hit or the end of the scan marks it
    always_comb
    begin
        strobe          = 1'b0;
        result_kind     = 1'b0;
        status          = stt_pkg::ST_OK;
        expired_session = '0;
        expired_kind    = '0;
        removed_count   = '0;
        last            = 1'b0;
        if (state_reg == stt_pkg::BK_CHECK && cur_reg.op == stt_pkg::OP_TICK
            && hit && pend_reg)
        begin
            strobe          = 1'b1;
            result_kind     = 1'b1;
            expired_session = pses_reg;
            expired_kind    = ptyp_reg;
        end
        else if (state_reg == stt_pkg::BK_DONE && pend_reg)
        begin
            strobe          = 1'b1;
            result_kind     = 1'b1;
            expired_session = pses_reg;
            expired_kind    = ptyp_reg;
            last            = 1'b1;
        end
        else if (state_reg == stt_pkg::BK_DONE && cur_reg.op != stt_pkg::OP_TICK)
        begin
            strobe = 1'b1;
            last   = 1'b1;
            unique case (cur_reg.op)
                stt_pkg::OP_ADD:
                    status = (cur_reg.tmo == '0 || !found_reg) ? stt_pkg::ST_REJECT
                                                                 : stt_pkg::ST_OK;
                stt_pkg::OP_CANCEL:
                    status = found_reg ? stt_pkg::ST_OK : stt_pkg::ST_NOTFOUND;
                stt_pkg::OP_CALL:
                    removed_count = 6'(cnt_reg);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= cmd;
        end
        prod_reg <= TW'(prod_w);
        if (state_reg == stt_pkg::BK_CHECK && hit)
        begin
            pses_reg <= r_ses;
            ptyp_reg <= r_typ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stt_pkg::BK_IDLE;
            valid_reg <= '0;
            now_reg   <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            slot_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            now_reg   <= now_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            slot_reg  <= slot_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ----- rtl/session_timer_table.sv -----
// Session timer table: top level joining command queue and table back end.
// Depends on stt_pkg, stt_front, stt_back.
// An add goes through the multiply and done states; cancel, cancel-all and tick first
// scan the table, and a cancel stops at its first match. Commands run one at a time.
// Reset empties the table, zeroes the tick count and sets ticks_per_second to 10.
// Results are strobed for one cycle; the receiver cannot stall.
module session_timer_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] session,
    input  logic [7:0]  timer_kind,
    input  logic [23:0] timeout_seconds,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    output logic        strobe,
    output logic        result_kind,
    output logic [1:0]  status,
    output logic [31:0] expired_session,
    output logic [7:0]  expired_kind,
    output logic [5:0]  removed_count,
    output logic        last
);

    logic [stt_pkg::TpsW-1:0] tps_reg;
    stt_pkg::cmd_t            in_cmd, head;
    logic                     full, not_empty, pop, active, push;

    assign cfg_ready = 1'b1;
    assign busy      = full;
    assign push      = start && !busy;
    assign in_cmd    = '{op: stt_pkg::op_t'(kind), session: session,
                         ttype: timer_kind, tmo: timeout_seconds};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= stt_pkg::TpsW'(10);
        end
        else if (cfg_valid && cfg_ready)
        begin
            tps_reg <= cfg_data;
        end
    end

    stt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (in_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    stt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (not_empty),
        .cmd             (head),
        .cmd_pop         (pop),
        .tps             (tps_reg),
        .active          (active),
        .strobe          (strobe),
        .result_kind     (result_kind),
        .status          (status),
        .expired_session (expired_session),
        .expired_kind    (expired_kind),
        .removed_count   (removed_count),
        .last            (last)
    );

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !active)
        else $error("command taken while back end busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last && result_kind == 1'b0) |=> !strobe)
        else $error("result after final response");

endmodule

// ----- tb/session_timer_table_test.sv -----
// Testbench for the session timer table: directed and random commands, a scoreboard
// class holding its own copy of the table and checking every strobed result.
// Depends on stt_pkg and the session_timer_table RTL.
module session_timer_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        rk;
        logic [1:0]  st;
        logic [31:0] ses;
        logic [7:0]  typ;
        logic [5:0]  cnt;
        logic        lst;
    } result_t;

    class timer_scoreboard;
        logic        valid [stt_pkg::MaxTimers];
        logic [31:0] ses [stt_pkg::MaxTimers];
        logic [7:0]  typ [stt_pkg::MaxTimers];
        logic [47:0] expiry [stt_pkg::MaxTimers];
        logic [47:0] now;
        logic [9:0]  tps;
        result_t     pending[$];
        int          errors;
        int          checked;
        int          expiries;

        function new();
            foreach (valid[i]) valid[i] = 1'b0;
            now = '0;
            tps = 10'd10;
            errors = 0;
            checked = 0;
            expiries = 0;
        endfunction

        function result_t resp(stt_pkg::status_t s, logic [5:0] c);
            result_t r;
            r = '0;
            r.st = s;
            r.cnt = c;
            r.lst = 1'b1;
            return r;
        endfunction

        function void note_command(stt_pkg::op_t op, logic [31:0] s, logic [7:0] t,
                                   logic [23:0] tmo);
            int slot;
            int n;
            int cnt;
            logic [47:0] mult;
            logic [47:0] diff;
            result_t r;
            slot = -1;
            n = 0;
            cnt = 0;
            case (op)
                stt_pkg::OP_ADD:
                begin
                    if (tmo != 0)
                        for (int i = stt_pkg::MaxTimers - 1; i >= 0; i--)
                            if (!valid[i]) slot = i;
                    if (slot < 0)
                        pending.push_back(resp(stt_pkg::ST_REJECT, 0));
                    else
                    begin
                        mult = 48'(tmo) * 48'((tps == 0) ? 10'd1 : tps);
                        valid[slot] = 1'b1;
                        ses[slot] = s;
                        typ[slot] = t;
                        expiry[slot] = now + mult;
                        pending.push_back(resp(stt_pkg::ST_OK, 0));
                    end
                end
                stt_pkg::OP_CANCEL:
                begin
                    for (int i = 0; i < stt_pkg::MaxTimers; i++)
                        if (slot < 0 && valid[i] && ses[i] == s && typ[i] == t) slot = i;
                    if (slot >= 0) valid[slot] = 1'b0;
                    pending.push_back(resp(slot >= 0 ? stt_pkg::ST_OK
                                                     : stt_pkg::ST_NOTFOUND, 0));
                end
                stt_pkg::OP_CALL:
                begin
                    for (int i = 0; i < stt_pkg::MaxTimers; i++)
                        if (valid[i] && ses[i] == s)
                        begin
                            valid[i] = 1'b0;
                            cnt++;
                        end
                    pending.push_back(resp(stt_pkg::ST_OK, (cnt > 63) ? 6'd63 : 6'(cnt)));
                end
                default:
                begin
                    now = now + 48'd1;
                    for (int i = 0; i < stt_pkg::MaxTimers && n < 32; i++)
                    begin
                        diff = now - expiry[i];
                        if (valid[i] && !diff[47])
                        begin
                            valid[i] = 1'b0;
                            r = '0;
                            r.rk = 1'b1;
                            r.ses = ses[i];
                            r.typ = typ[i];
                            pending.push_back(r);
                            n++;
                        end
                    end
                    if (n > 0)
                    begin
                        r = pending.pop_back();
                        r.lst = 1'b1;
                        pending.push_back(r);
                    end
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.rk) expiries++;
            if (got.rk !== want.rk)
                $display("%0t: result_kind expected %0d actual %0d", $time, want.rk, got.rk);
            if (got.st !== want.st)
                $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            if (got.ses !== want.ses)
                $display("%0t: expired_session expected %h actual %h", $time, want.ses, got.ses);
            if (got.typ !== want.typ)
                $display("%0t: expired_kind expected %h actual %h", $time, want.typ, got.typ);
            if (got.cnt !== want.cnt)
                $display("%0t: removed_count expected %0d actual %0d", $time, want.cnt, got.cnt);
            if (got.lst !== want.lst)
                $display("%0t: last expected %0d actual %0d", $time, want.lst, got.lst);
            if (got !== want) errors++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = '0;
    logic [31:0] session = '0;
    logic [7:0]  timer_kind = '0;
    logic [23:0] timeout_seconds = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;
    logic        strobe;
    logic        result_kind;
    logic [1:0]  status;
    logic [31:0] expired_session;
    logic [7:0]  expired_kind;
    logic [5:0]  removed_count;
    logic        last;

    timer_scoreboard board;
    int          idle_pct;
    int          commands;
    logic [31:0] session_pool [8];

    session_timer_table uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        if (rst_n && strobe)
            board.check_result({result_kind, status, expired_session, expired_kind,
                removed_count, last});

    task automatic send(stt_pkg::op_t op, logic [31:0] s, logic [7:0] t, logic [23:0] tmo);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        kind <= op;
        session <= s;
        timer_kind <= t;
        timeout_seconds <= tmo;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_command(op, s, t, tmo);
        commands++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_rate(logic [9:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.tps = v;
    endtask

    task automatic random_command();
        int pick;
        logic [31:0] s;
        logic [23:0] tmo;
        pick = $urandom_range(99);
        s = ($urandom_range(9) == 0) ? $urandom : session_pool[$urandom_range(7)];
        tmo = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(4));
        if (pick < 30)
            send(stt_pkg::OP_ADD, s, 8'($urandom_range(3)), tmo);
        else if (pick < 42)
            send(stt_pkg::OP_CANCEL, s,
                 ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                 24'($urandom));
        else if (pick < 50)
            send(stt_pkg::OP_CALL, s, 8'($urandom), 24'($urandom));
        else
            send(stt_pkg::OP_TICK, $urandom, 8'($urandom), 24'($urandom));
    endtask

    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        board = new();
        idle_pct = 0;
        commands = 0;
        foreach (session_pool[i]) session_pool[i] = $urandom;
        session_pool[0] = 32'hFFFF_FFFF;
        session_pool[1] = 32'h0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, rejects, misses, a full table and a burst of expiries
        write_rate(10'd1);
        send(stt_pkg::OP_ADD, 32'h1234, 8'h01, 24'd0);
        send(stt_pkg::OP_ADD, 32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF);
        send(stt_pkg::OP_CANCEL, 32'h5555, 8'h01, 24'd0);
        send(stt_pkg::OP_CALL, 32'h5555, 8'h00, 24'd0);
        send(stt_pkg::OP_CANCEL, 32'hFFFF_FFFF, 8'hFF, 24'd0);
        send(stt_pkg::OP_TICK, 32'h0, 8'h0, 24'd0);
        for (int i = 0; i < 33; i++)
            send(stt_pkg::OP_ADD, (i < 20) ? 32'hAAAA_0000 : 32'h0, 8'(i), 24'd1);
        send(stt_pkg::OP_TICK, 32'h0, 8'h0, 24'd0);
        send(stt_pkg::OP_CALL, 32'hAAAA_0000, 8'h0, 24'd0);
        send(stt_pkg::OP_TICK, 32'h0, 8'h0, 24'd0);
        write_rate(10'd0);
        send(stt_pkg::OP_ADD, 32'h7, 8'h7, 24'd2);
        send(stt_pkg::OP_TICK, 32'h0, 8'h0, 24'd0);
        send(stt_pkg::OP_TICK, 32'h0, 8'h0, 24'd0);

        // random phases over rates and idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_rate(10'd1023);
                1: write_rate(10'd1000);
                2: write_rate(10'd2);
                3: write_rate(10'd1);
                default: write_rate(10'($urandom_range(1, 5)));
            endcase
            idle_pct = (ph == 1) ? 64 : (ph == 3) ? 21 : 0;
            for (int i = 0; i < 70; i++)
                random_command();
            idle_pct = 0;
            for (int i = 0; i < 20; i++)
                send(stt_pkg::OP_TICK, 32'h0, 8'h0, 24'd0);
        end
        drain();

        $display("Ran %0d commands, checked %0d results including %0d expiries.",
            commands, board.checked, board.expiries);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
